// ===== design/rtxy_pkg.sv =====
// Shared types, widths and elaboration-time table functions for the RGB to xy
// chromaticity block. No dependencies.
`default_nettype none
package rtxy_pkg;

  localparam int CHAN_W = 8;
  localparam int FADE_W = 8;
  localparam int CHROMA_W = 16;
  localparam int QUOT_W = 18;
  localparam int ROM_DEPTH = 256;

  typedef struct packed {
    logic              valid;
    logic              light_off;
    logic              no_ratio;
    logic [FADE_W-1:0] fade;
  } rtxy_side_t;

  function automatic longint unsigned rtxy_pow5(longint unsigned r);
    longint unsigned a;
    longint unsigned b;
    a = (r * r) >> 30;
    b = (a * a) >> 30;
    return (b * r) >> 30;
  endfunction

  // Linearized sRGB value of code c in Q1.frac.
  function automatic longint unsigned rtxy_gamma(longint unsigned c, int frac);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned l;
    if (c <= 10) begin
      return (((c * 10) << (frac + 1)) + 32946) / 65892;
    end
    t = (((c * 1000 + 14025) << 30) + 134512) / 269025;
    t2 = (t * t + (64'd1 << 29)) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (rtxy_pow5(mid) <= t2) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    l = (t2 * lo + (64'd1 << 29)) >> 30;
    return (l + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

  function automatic longint unsigned rtxy_coef(longint unsigned micro, int frac);
    return ((micro << frac) + 500000) / 1000000;
  endfunction

endpackage
`default_nettype wire

// ===== design/rgb_to_xy_chromaticity_top.sv =====
// The datapath is a chain of 18 division cells behind the front stages.
// Throughput: one transaction per cycle while the skid register is empty.
// Four front stages do the gamma lookup, products and sums; one output register follows.
// Reset (rst_ni low, asynchronous) empties the pipeline and the output and skid registers.
// Depends on rtxy_pkg, rtxy_front and rtxy_div_cell.
`default_nettype none
module rgb_to_xy_chromaticity_top import rtxy_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CHAN_W-1:0]   red_i,
  input  wire logic [CHAN_W-1:0]   green_i,
  input  wire logic [CHAN_W-1:0]   blue_i,
  input  wire logic [FADE_W-1:0]   fade_time_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CHROMA_W-1:0]      chroma_x_o,
  output logic [CHROMA_W-1:0]      chroma_y_o,
  output logic                     light_off_o,
  output logic [FADE_W-1:0]        fade_out_o
);

  localparam int SW = 2 * FRAC_BITS + 3;

  typedef struct packed {
    logic [CHROMA_W-1:0] cx;
    logic [CHROMA_W-1:0] cy;
    logic                off;
    logic [FADE_W-1:0]   fade;
  } result_t;

  // The whole pipeline advances together unless the skid register holds a result.
  logic en;
  logic skid_valid_q, out_valid_q;
  result_t skid_q, out_q, pipe_res;

  assign en = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  rtxy_side_t side_c [QUOT_W+1];
  logic [SW-1:0] den_c [QUOT_W+1];
  logic [SW:0] rx_c [QUOT_W+1];
  logic [SW:0] ry_c [QUOT_W+1];
  logic [QUOT_W-1:0] qx_c [QUOT_W+1];
  logic [QUOT_W-1:0] qy_c [QUOT_W+1];
  logic [SW-1:0] fx, fy;

  rtxy_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .fade_i  (fade_time_i),
    .side_o  (side_c[0]),
    .x_o     (fx),
    .y_o     (fy),
    .s_o     (den_c[0])
  );

  assign rx_c[0] = {1'b0, fx};
  assign ry_c[0] = {1'b0, fy};
  assign qx_c[0] = '0;
  assign qy_c[0] = '0;

  // Each cell settles one quotient bit of x and y and hands the remainders on.
  for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
    rtxy_div_cell #(.SW(SW), .FIRST(i == 0)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (side_c[i]),
      .den_i  (den_c[i]),
      .rx_i   (rx_c[i]),
      .ry_i   (ry_c[i]),
      .qx_i   (qx_c[i]),
      .qy_i   (qy_c[i]),
      .side_o (side_c[i+1]),
      .den_o  (den_c[i+1]),
      .rx_o   (rx_c[i+1]),
      .ry_o   (ry_c[i+1]),
      .qx_o   (qx_c[i+1]),
      .qy_o   (qy_c[i+1])
    );
  end

  logic [QUOT_W:0] rnd_x, rnd_y;
  logic gate;

  // Round the quotient to 16 fractional bits and saturate; black or a zero
  // sum forces both coordinates to zero.
  always_comb begin
    rnd_x = ({1'b0, qx_c[QUOT_W]} + 1'b1) >> 1;
    rnd_y = ({1'b0, qy_c[QUOT_W]} + 1'b1) >> 1;
    gate = side_c[QUOT_W].light_off || side_c[QUOT_W].no_ratio;
    pipe_res.cx = gate ? '0 : (rnd_x > 19'd65535 ? 16'hFFFF : rnd_x[CHROMA_W-1:0]);
    pipe_res.cy = gate ? '0 : (rnd_y > 19'd65535 ? 16'hFFFF : rnd_y[CHROMA_W-1:0]);
    pipe_res.off = side_c[QUOT_W].light_off;
    pipe_res.fade = side_c[QUOT_W].fade;
  end

  // Output register with a skid register behind it, so a stalled result
  // never blocks the transaction that arrives in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= side_c[QUOT_W].valid;
      end
    end else if (side_c[QUOT_W].valid && en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : pipe_res;
    end else if (side_c[QUOT_W].valid && en) begin
      skid_q <= pipe_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign chroma_x_o = out_q.cx;
  assign chroma_y_o = out_q.cy;
  assign light_off_o = out_q.off;
  assign fade_out_o = out_q.fade;

endmodule
`default_nettype wire

// ===== design/rtxy_front.sv =====
// Front end: gamma table lookup, matrix products and XYZ sums, four stages.
// Depends on rtxy_pkg.
`default_nettype none
module rtxy_front import rtxy_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int SW = 2 * FRAC_BITS + 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [CHAN_W-1:0] red_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic [FADE_W-1:0] fade_i,
  output rtxy_side_t             side_o,
  output logic [SW-1:0]          x_o,
  output logic [SW-1:0]          y_o,
  output logic [SW-1:0]          s_o
);

  localparam int EW = FRAC_BITS + 1;
  localparam int CW = FRAC_BITS;
  localparam int PW = 2 * FRAC_BITS + 1;

  typedef logic [EW-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int c = 0; c < ROM_DEPTH; c++) begin
      rom[c] = EW'(rtxy_gamma(longint'(c), FRAC_BITS));
    end
    return rom;
  endfunction

  localparam rom_t GAMMA = build_rom();

  localparam logic [CW-1:0] K_XR = CW'(rtxy_coef(664511, FRAC_BITS));
  localparam logic [CW-1:0] K_XG = CW'(rtxy_coef(154324, FRAC_BITS));
  localparam logic [CW-1:0] K_XB = CW'(rtxy_coef(162028, FRAC_BITS));
  localparam logic [CW-1:0] K_YR = CW'(rtxy_coef(283881, FRAC_BITS));
  localparam logic [CW-1:0] K_YG = CW'(rtxy_coef(668433, FRAC_BITS));
  localparam logic [CW-1:0] K_YB = CW'(rtxy_coef(47685, FRAC_BITS));
  localparam logic [CW-1:0] K_ZR = CW'(rtxy_coef(88, FRAC_BITS));
  localparam logic [CW-1:0] K_ZG = CW'(rtxy_coef(72310, FRAC_BITS));
  localparam logic [CW-1:0] K_ZB = CW'(rtxy_coef(986039, FRAC_BITS));

  rtxy_side_t s1_q, s2_q, s3_q, s4_q;
  logic [EW-1:0] lr_q, lg_q, lb_q;
  logic [PW-1:0] p_q [9];
  logic [SW-1:0] cx_q, cy_q, cz_q;
  logic [SW-1:0] x4_q, y4_q, sum4_q;
  rtxy_side_t s1_d;

  always_comb begin
    s1_d.valid = valid_i;
    s1_d.light_off = (red_i == '0) && (green_i == '0) && (blue_i == '0);
    s1_d.no_ratio = 1'b0;
    s1_d.fade = fade_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lr_q <= GAMMA[red_i];
      lg_q <= GAMMA[green_i];
      lb_q <= GAMMA[blue_i];
      p_q[0] <= PW'(lr_q * K_XR);
      p_q[1] <= PW'(lg_q * K_XG);
      p_q[2] <= PW'(lb_q * K_XB);
      p_q[3] <= PW'(lr_q * K_YR);
      p_q[4] <= PW'(lg_q * K_YG);
      p_q[5] <= PW'(lb_q * K_YB);
      p_q[6] <= PW'(lr_q * K_ZR);
      p_q[7] <= PW'(lg_q * K_ZG);
      p_q[8] <= PW'(lb_q * K_ZB);
      cx_q <= SW'(p_q[0]) + SW'(p_q[1]) + SW'(p_q[2]);
      cy_q <= SW'(p_q[3]) + SW'(p_q[4]) + SW'(p_q[5]);
      cz_q <= SW'(p_q[6]) + SW'(p_q[7]) + SW'(p_q[8]);
      x4_q <= cx_q;
      y4_q <= cy_q;
      sum4_q <= cx_q + cy_q + cz_q;
    end
  end

  assign side_o = s4_q;
  assign x_o = x4_q;
  assign y_o = y4_q;
  assign s_o = sum4_q;

endmodule
`default_nettype wire

// ===== design/rtxy_div_cell.sv =====
// One restoring-division cell: produces one quotient bit of x and of y.
// Depends on rtxy_pkg.
`default_nettype none
module rtxy_div_cell import rtxy_pkg::*; #(
  parameter int SW = 35,
  parameter bit FIRST = 1'b0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  rtxy_side_t             side_i,
  input  wire logic [SW-1:0]     den_i,
  input  wire logic [SW:0]       rx_i,
  input  wire logic [SW:0]       ry_i,
  input  wire logic [QUOT_W-1:0] qx_i,
  input  wire logic [QUOT_W-1:0] qy_i,
  output rtxy_side_t             side_o,
  output logic [SW-1:0]          den_o,
  output logic [SW:0]            rx_o,
  output logic [SW:0]            ry_o,
  output logic [QUOT_W-1:0]      qx_o,
  output logic [QUOT_W-1:0]      qy_o
);

  rtxy_side_t side_d, side_q;
  logic [SW:0] rx_d, ry_d, rx_q, ry_q, sx, sy, den_w;
  logic [QUOT_W-1:0] qx_d, qy_d, qx_q, qy_q, tx, ty;
  logic [SW-1:0] den_q;

  always_comb begin
    den_w = {1'b0, den_i};
    // The first cell only compares; the others shift by one bit first.
    sx = FIRST ? rx_i : {rx_i[SW-1:0], 1'b0};
    sy = FIRST ? ry_i : {ry_i[SW-1:0], 1'b0};
    tx = FIRST ? qx_i : {qx_i[QUOT_W-2:0], 1'b0};
    ty = FIRST ? qy_i : {qy_i[QUOT_W-2:0], 1'b0};
    rx_d = (sx >= den_w) ? sx - den_w : sx;
    ry_d = (sy >= den_w) ? sy - den_w : sy;
    qx_d = {tx[QUOT_W-1:1], tx[0] | (sx >= den_w)};
    qy_d = {ty[QUOT_W-1:1], ty[0] | (sy >= den_w)};
    side_d = side_i;
    if (FIRST) begin
      side_d.no_ratio = (den_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      rx_q <= rx_d;
      ry_q <= ry_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
  end

  assign side_o = side_q;
  assign den_o = den_q;
  assign rx_o = rx_q;
  assign ry_o = ry_q;
  assign qx_o = qx_q;
  assign qy_o = qy_q;

endmodule
`default_nettype wire

// ===== dv/rgb_to_xy_chromaticity_checker.sv =====
// Scoreboard for the RGB to xy chromaticity block: watches both channels,
// predicts each result and compares. Depends on rtxy_pkg for widths.
module rgb_to_xy_chromaticity_checker import rtxy_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [CHAN_W-1:0]   red_i,
  input  logic [CHAN_W-1:0]   green_i,
  input  logic [CHAN_W-1:0]   blue_i,
  input  logic [FADE_W-1:0]   fade_time_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [CHROMA_W-1:0] chroma_x_i,
  input  logic [CHROMA_W-1:0] chroma_y_i,
  input  logic                light_off_i,
  input  logic [FADE_W-1:0]   fade_out_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHROMA_W-1:0] cx;
    logic [CHROMA_W-1:0] cy;
    logic                off;
    logic [FADE_W-1:0]   fade;
  } chroma_t;

  chroma_t chroma_q[$];
  longint unsigned lin_lut[256];

  function automatic longint unsigned fifth_power(longint unsigned r);
    longint unsigned a, b;
    a = (r * r) >> 30;
    b = (a * a) >> 30;
    return (b * r) >> 30;
  endfunction

  function automatic longint unsigned linearize(longint unsigned c);
    longint unsigned t, t2, lo, hi, mid, l;
    if (c <= 10) return (((c * 10) << (FRAC_BITS + 1)) + 32946) / 65892;
    t = (((c * 1000 + 14025) << 30) + 134512) / 269025;
    t2 = (t * t + (64'd1 << 29)) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (fifth_power(mid) <= t2) lo = mid;
      else hi = mid - 1;
    end
    l = (t2 * lo + (64'd1 << 29)) >> 30;
    return (l + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  function automatic longint unsigned kq(longint unsigned micro);
    return ((micro << FRAC_BITS) + 500000) / 1000000;
  endfunction

  // Rounded Q0.16 quotient, saturated.
  function automatic longint unsigned quot16(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = ((num << 17) / den + 1) >> 1;
    return (q > 65535) ? 65535 : q;
  endfunction

  function automatic chroma_t predict_chroma(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             logic [7:0] f);
    chroma_t e;
    longint unsigned lr, lg, lb, sx, sy, sz, s;
    e = '0;
    e.fade = f;
    if (r == 0 && g == 0 && b == 0) begin
      e.off = 1'b1;
      return e;
    end
    lr = lin_lut[r];
    lg = lin_lut[g];
    lb = lin_lut[b];
    sx = lr * kq(664511) + lg * kq(154324) + lb * kq(162028);
    sy = lr * kq(283881) + lg * kq(668433) + lb * kq(47685);
    sz = lr * kq(88) + lg * kq(72310) + lb * kq(986039);
    s = sx + sy + sz;
    if (s != 0) begin
      e.cx = CHROMA_W'(quot16(sx, s));
      e.cy = CHROMA_W'(quot16(sy, s));
    end
    return e;
  endfunction

  initial begin
    fail_count_o = 0;
    results_seen_o = 0;
    for (int i = 0; i < 256; i++) lin_lut[i] = linearize(i);
  end

  assign pending_o = chroma_q.size();

  always @(posedge clk_i) begin
    chroma_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        chroma_q.push_back(predict_chroma(red_i, green_i, blue_i, fade_time_i));
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (chroma_q.size() == 0) begin
          $error("result with no prediction waiting");
          fail_count_o++;
        end else begin
          e = chroma_q.pop_front();
          if (chroma_x_i !== e.cx) begin
            $error("chroma_x expected %0d actual %0d", e.cx, chroma_x_i);
            fail_count_o++;
          end
          if (chroma_y_i !== e.cy) begin
            $error("chroma_y expected %0d actual %0d", e.cy, chroma_y_i);
            fail_count_o++;
          end
          if (light_off_i !== e.off) begin
            $error("light_off expected %0d actual %0d", e.off, light_off_i);
            fail_count_o++;
          end
          if (fade_out_i !== e.fade) begin
            $error("fade_out expected %0d actual %0d", e.fade, fade_out_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_rgb_to_xy_chromaticity_top.sv =====
// Top-level testbench for the RGB to xy chromaticity block: clock, reset,
// stimulus, output stalls and verdict. Depends on rtxy_pkg and the checker.
module tb_rgb_to_xy_chromaticity_top;
  import rtxy_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1150;
  localparam int LATENCY = 23;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAN_W-1:0] red = '0, green = '0, blue = '0;
  logic [FADE_W-1:0] fade = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CHROMA_W-1:0] chroma_x, chroma_y;
  logic light_off;
  logic [FADE_W-1:0] fade_out;
  int fail_count, pending, results_seen;
  int items_sent = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off_done = 1'b0;

  always #6 clk_i = ~clk_i;

  rgb_to_xy_chromaticity_top u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .red_i(red), .green_i(green), .blue_i(blue), .fade_time_i(fade),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .chroma_x_o(chroma_x), .chroma_y_o(chroma_y),
    .light_off_o(light_off), .fade_out_o(fade_out)
  );

  rgb_to_xy_chromaticity_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .red_i(red), .green_i(green), .blue_i(blue), .fade_time_i(fade),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .chroma_x_i(chroma_x), .chroma_y_i(chroma_y),
    .light_off_i(light_off), .fade_out_i(fade_out),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Gap lengths: mostly zero or short, occasionally long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one transaction and hold it stable until the block takes it. The
  // valid line stays high across back-to-back transactions, so it is only
  // lowered when a gap actually follows.
  task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic [7:0] f, input int gap);
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    fade <= f;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: random stalls, with a stall-free stretch early on and one long
  // hold-off in the middle so the pipeline fills and backs up the input.
  initial begin
    int g;
    wait (rst_ni);
    repeat (60) @(posedge clk_i);
    forever begin
      if (!hold_off_done && items_sent > 300) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      g = pick_gap();
      out_stall <= (g > 0);
      repeat ((g > 0) ? g : 1) @(posedge clk_i);
      if (g > 0) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // The watchdog counts cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int p;
    logic [7:0] r, g, b;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: black, white, each primary at full, the linear segment
    // boundary around codes 10 and 11, and alternating bit patterns.
    send_rgb(8'd0, 8'd0, 8'd0, 8'd0, 0);
    send_rgb(8'd0, 8'd0, 8'd0, 8'd255, 0);
    send_rgb(8'd255, 8'd255, 8'd255, 8'd170, 0);
    send_rgb(8'd255, 8'd0, 8'd0, 8'd85, 1);
    send_rgb(8'd0, 8'd255, 8'd0, 8'd1, 0);
    send_rgb(8'd0, 8'd0, 8'd255, 8'd128, 2);
    send_rgb(8'd1, 8'd0, 8'd0, 8'd7, 0);
    send_rgb(8'd0, 8'd1, 8'd0, 8'd9, 0);
    send_rgb(8'd0, 8'd0, 8'd1, 8'd11, 0);
    send_rgb(8'd10, 8'd10, 8'd10, 8'd12, 0);
    send_rgb(8'd11, 8'd11, 8'd11, 8'd13, 0);
    send_rgb(8'd10, 8'd11, 8'd12, 8'd14, 0);
    send_rgb(8'd170, 8'd85, 8'd170, 8'd85, 0);
    send_rgb(8'd85, 8'd170, 8'd85, 8'd170, 0);
    send_rgb(8'd255, 8'd255, 8'd0, 8'd254, 0);
    send_rgb(8'd0, 8'd255, 8'd255, 8'd127, 0);
    send_rgb(8'd255, 8'd0, 8'd255, 8'd64, 0);
    send_rgb(8'd128, 8'd128, 8'd128, 8'd32, 3);

    // Random part: mostly uniform triples, with some drawn near black and
    // near the linear segment to keep small values well represented.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      p = $urandom_range(0, 9);
      if (p < 6) begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end else if (p < 9) begin
        r = 8'($urandom_range(0, 12));
        g = 8'($urandom_range(0, 12));
        b = 8'($urandom_range(0, 12));
      end else begin
        r = '0;
        g = '0;
        b = '0;
      end
      send_rgb(r, g, b, 8'($urandom), pick_gap());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("tb: %0d input transactions sent, %0d results checked,", items_sent,
             results_seen);
    $display("tb: black, primaries, linear segment edge and a long output hold-off covered");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/rtxy_pkg.sv
design/rtxy_front.sv
design/rtxy_div_cell.sv
design/rgb_to_xy_chromaticity_top.sv
dv/rgb_to_xy_chromaticity_checker.sv
dv/tb_rgb_to_xy_chromaticity_top.sv
